>>> rtl/zcpe_pkg.sv
package zcpe_pkg;

  // operation codes of an input beat
  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_ZERO   = 2'd1,
    OP_PERIOD = 2'd2
  } op_t;

  // configuration register indexes
  localparam int unsigned CFG_IDX_BITS  = 1;
  localparam int unsigned CFG_DATA_BITS = 5;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_ACTIVE_BANKS    = 1'd0,
    CFG_ACTIVE_CHANNELS = 1'd1
  } cfg_reg_t;

  // fixed field widths
  localparam int unsigned BANK_BITS  = 2;
  localparam int unsigned CHAN_BITS  = 4;
  localparam int unsigned PEAK_BITS  = 15;
  localparam int unsigned ZERO_BITS  = 16;
  localparam int unsigned OUT_BITS   = 16;
  localparam int unsigned PEAK_CAP   = 32767;
  localparam int unsigned OUT_CAP    = 65535;

  // control travelling with an entry update
  typedef struct packed {
    logic                 is_sample;
    logic [BANK_BITS-1:0] bank;
    logic [CHAN_BITS-1:0] channel;
  } upd_ctl_t;

  // one result beat
  typedef struct packed {
    logic [BANK_BITS-1:0] bank;
    logic [CHAN_BITS-1:0] channel;
    logic [PEAK_BITS-1:0] magnitude;
    logic [OUT_BITS-1:0]  period;
    logic [OUT_BITS-1:0]  since_rise;
    logic [OUT_BITS-1:0]  since_fall;
  } res_t;

endpackage

>>> rtl/zcpe_state_mem.sv
module zcpe_state_mem import zcpe_pkg::*; #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 94,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  output logic             clr_busy
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;
  logic             clr_busy_r;
  logic [AW-1:0]    clr_addr_r;

  // clearing pass after reset, one entry a cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      if (clr_addr_r == AW'(DEPTH - 1)) begin
        clr_busy_r <= 1'b0;
      end
      clr_addr_r <= clr_addr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem[clr_addr_r] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data  = rd_data_r;
  assign clr_busy = clr_busy_r;

endmodule

>>> rtl/zcpe_update.sv
module zcpe_update import zcpe_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned COUNT_BITS  = 16,
  parameter int unsigned WORD_BITS   = 2 * PEAK_BITS + 3 * COUNT_BITS + ZERO_BITS
) (
  input  upd_ctl_t                ctl,
  input  logic signed [15:0]      sample,
  input  logic signed [15:0]      new_zero,
  input  logic [COUNT_BITS-1:0]   gap,
  input  logic [WORD_BITS-1:0]    entry_in,
  output logic [WORD_BITS-1:0]    entry_out,
  output res_t                    result
);

  localparam int unsigned CB = COUNT_BITS;
  localparam int unsigned SB = SAMPLE_BITS;
  localparam int unsigned DW = (SB > 16) ? SB : 16;
  localparam logic [CB-1:0] CNT_MAX = '1;
  localparam logic [SB-1:0] SMP_SIGN = SB'(1) << (SB - 1);

  // word layout, lsb first
  localparam int unsigned RPK_LO = 0;
  localparam int unsigned LPK_LO = RPK_LO + PEAK_BITS;
  localparam int unsigned RIS_LO = LPK_LO + PEAK_BITS;
  localparam int unsigned FAL_LO = RIS_LO + CB;
  localparam int unsigned PER_LO = FAL_LO + CB;
  localparam int unsigned ZER_LO = PER_LO + CB;

  function automatic logic [CB-1:0] sat_inc(input logic [CB-1:0] v);
    return (v == CNT_MAX) ? v : v + 1'b1;
  endfunction

  function automatic logic [OUT_BITS-1:0] cap_out(input logic [CB-1:0] v);
    return (32'(v) > OUT_CAP) ? OUT_BITS'(OUT_CAP) : OUT_BITS'(v);
  endfunction

  function automatic logic [CB-1:0] twice_sat(input logic [CB-1:0] d);
    return d[CB-1] ? CNT_MAX : {d[CB-2:0], 1'b0};
  endfunction

  logic [PEAK_BITS-1:0]        rpk, lpk;
  logic [CB-1:0]               rise, fall, per;
  logic signed [ZERO_BITS-1:0] zero_s;
  logic [DW-1:0]               d_full;
  logic [SB-1:0]               diff, mag_w;
  logic                        neg;
  logic [PEAK_BITS-1:0]        mag, peak;
  logic [CB-1:0]               r1, f1;

  always_comb begin
    rpk    = entry_in[RPK_LO +: PEAK_BITS];
    lpk    = entry_in[LPK_LO +: PEAK_BITS];
    rise   = entry_in[RIS_LO +: CB];
    fall   = entry_in[FAL_LO +: CB];
    per    = entry_in[PER_LO +: CB];
    zero_s = entry_in[ZER_LO +: ZERO_BITS];

    // shifted sample, wrapped at the sample width
    d_full = DW'(sample) - DW'(zero_s);
    diff   = d_full[SB-1:0];
    neg    = diff[SB-1];
    if (!neg) begin
      mag_w = diff;
    end else if (diff == SMP_SIGN) begin
      mag_w = SMP_SIGN - 1'b1;
    end else begin
      mag_w = -diff;
    end
    mag  = (32'(mag_w) > PEAK_CAP) ? PEAK_BITS'(PEAK_CAP) : PEAK_BITS'(mag_w);
    peak = (mag > rpk) ? mag : rpk;

    r1 = sat_inc(rise);
    f1 = sat_inc(fall);

    entry_out = entry_in;
    if (!ctl.is_sample) begin
      entry_out[ZER_LO +: ZERO_BITS] = new_zero;
    end else begin
      entry_out[RPK_LO +: PEAK_BITS] = peak;
      entry_out[RIS_LO +: CB]        = r1;
      entry_out[FAL_LO +: CB]        = f1;
      if (r1 > f1) begin
        // negative lobe, looking for a rising crossing
        if (!neg && f1 >= gap) begin
          entry_out[PER_LO +: CB]        = twice_sat(r1 - f1);
          entry_out[LPK_LO +: PEAK_BITS] = peak;
          entry_out[RPK_LO +: PEAK_BITS] = mag;
          entry_out[RIS_LO +: CB]        = '0;
        end
      end else begin
        // positive lobe (or equal counters), looking for a falling crossing
        if (neg && r1 >= gap) begin
          entry_out[PER_LO +: CB]        = twice_sat(f1 - r1);
          entry_out[LPK_LO +: PEAK_BITS] = peak;
          entry_out[RPK_LO +: PEAK_BITS] = mag;
          entry_out[FAL_LO +: CB]        = '0;
        end
      end
    end

    result.bank       = ctl.bank;
    result.channel    = ctl.channel;
    result.magnitude  = entry_out[LPK_LO +: PEAK_BITS];
    result.period     = cap_out(entry_out[PER_LO +: CB]);
    result.since_rise = cap_out(entry_out[RIS_LO +: CB]);
    result.since_fall = cap_out(entry_out[FAL_LO +: CB]);
    // unused in zero-level writes
    if (!ctl.is_sample) begin
      result.magnitude = lpk;
      result.period    = cap_out(per);
    end
  end

endmodule

>>> rtl/zcpe_res_fifo.sv
module zcpe_res_fifo import zcpe_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  res_t       push_data,
  input  logic       pop,
  output logic       not_empty,
  output res_t       head,
  output logic [1:0] count
);

  res_t       data_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r, cnt_nxt;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (!push && pop) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      data_r[wr_ptr_r] <= push_data;
    end
  end

  assign not_empty = (cnt_r != 2'd0);
  assign head      = data_r[rd_ptr_r];
  assign count     = cnt_r;

endmodule

>>> rtl/zero_crossing_phase_estimator_bank_core.sv
// zero-crossing period and amplitude estimator bank
//
// input channel (in_valid / in_stall): one beat per cycle carries an operation,
// a bank and a channel. operation sample updates that channel's estimator and
// gives one result beat; set zero level and set bank minimum period give none,
// nor does a sample for an inactive or out-of-range channel.
// result channel (out_valid / out_stall): address, latched peak magnitude,
// period and the two since-crossing counts after the update.
// configuration: cfg_we with cfg_index / cfg_wdata writes active_banks or
// active_channels; writes are taken at any time, also during the clear.
// throughput: one beat per cycle sustained while in_stall is low. each sample
// or zero-level beat is a read-modify-write of its channel's entry in a
// single-port-read state memory; back-to-back access to one entry is served
// from a bypass register. an accepted beat is registered into the update
// stage; a sample's result then enters the result buffer and is offered from
// it. reset: rst_n (synchronous) starts a clearing pass over all BANK_COUNT *
// CHANNEL_COUNT entries (64 by default), during which in_stall is high. results
// queue in a two-beat buffer, and in_stall also rises when it is about to fill.
module zero_crossing_phase_estimator_bank_core import zcpe_pkg::*; #(
  parameter int unsigned BANK_COUNT    = 4,
  parameter int unsigned CHANNEL_COUNT = 16,
  parameter int unsigned SAMPLE_BITS   = 16,
  parameter int unsigned COUNT_BITS    = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // configuration port
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
  // input channel
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               in_operation,
  input  logic [BANK_BITS-1:0]     in_bank,
  input  logic [CHAN_BITS-1:0]     in_channel,
  input  logic signed [15:0]       in_sample,
  input  logic signed [15:0]       in_new_zero,
  input  logic [15:0]              in_new_min_period,
  // result channel
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [BANK_BITS-1:0]     out_bank,
  output logic [CHAN_BITS-1:0]     out_channel,
  output logic [PEAK_BITS-1:0]     out_magnitude,
  output logic [OUT_BITS-1:0]      out_period,
  output logic [OUT_BITS-1:0]      out_since_rise,
  output logic [OUT_BITS-1:0]      out_since_fall
);

  localparam int unsigned SLOTS     = BANK_COUNT * CHANNEL_COUNT;
  localparam int unsigned SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned GAP_IW    = (BANK_COUNT > 1) ? $clog2(BANK_COUNT) : 1;
  localparam int unsigned AB_W      = ($clog2(BANK_COUNT + 1) > 3) ?
                                      $clog2(BANK_COUNT + 1) : 3;
  localparam int unsigned AC_W      = ($clog2(CHANNEL_COUNT + 1) > 5) ?
                                      $clog2(CHANNEL_COUNT + 1) : 5;
  localparam int unsigned WORD_BITS = 2 * PEAK_BITS + 3 * COUNT_BITS + ZERO_BITS;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  // configuration registers
  logic [AB_W-1:0] active_banks_r;
  logic [AC_W-1:0] active_channels_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_banks_r    <= AB_W'(BANK_COUNT);
      active_channels_r <= AC_W'(CHANNEL_COUNT);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_ACTIVE_BANKS: begin
          // saturate to the bank count
          active_banks_r <= (32'(cfg_wdata[2:0]) > BANK_COUNT) ?
                            AB_W'(BANK_COUNT) : AB_W'(cfg_wdata[2:0]);
        end
        CFG_ACTIVE_CHANNELS: begin
          active_channels_r <= (32'(cfg_wdata) > CHANNEL_COUNT) ?
                               AC_W'(CHANNEL_COUNT) : AC_W'(cfg_wdata);
        end
      endcase
    end
  end

  // accept stage: decode and issue the memory read
  logic              in_accept;
  logic              clr_busy;
  op_t               op_c;
  logic              in_range, in_active;
  logic              s0_rmw, s0_sample, s0_gap_we;
  logic [SLOT_W-1:0] s0_slot;
  logic [14:0]       half_period;
  logic [COUNT_BITS-1:0] gap_nxt;

  assign in_accept = in_valid && !in_stall;

  always_comb begin
    op_c      = op_t'(in_operation);
    in_range  = (32'(in_bank) < BANK_COUNT) && (32'(in_channel) < CHANNEL_COUNT);
    in_active = (32'(in_bank) < 32'(active_banks_r)) &&
                (32'(in_channel) < 32'(active_channels_r));
    s0_rmw    = 1'b0;
    s0_sample = 1'b0;
    s0_gap_we = 1'b0;
    unique case (op_c)
      OP_SAMPLE: begin
        s0_rmw    = in_range && in_active;
        s0_sample = in_range && in_active;
      end
      OP_ZERO: begin
        s0_rmw = in_range;
      end
      OP_PERIOD: begin
        s0_gap_we = (32'(in_bank) < BANK_COUNT);
      end
      default: begin
        // unused code, beat dropped
      end
    endcase
    s0_slot     = SLOT_W'(32'(in_bank) * CHANNEL_COUNT + 32'(in_channel));
    // minimum gap is half the minimum period
    half_period = in_new_min_period[15:1];
    gap_nxt     = (32'(half_period) > 32'(CNT_MAX)) ?
                  CNT_MAX : COUNT_BITS'(half_period);
  end

  // per-bank minimum gap, all ones after reset so a crossing is detected only once its counter saturates
  logic [COUNT_BITS-1:0] gap_r [BANK_COUNT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < BANK_COUNT; i++) begin
        gap_r[i] <= CNT_MAX;
      end
    end else if (in_accept && s0_gap_we) begin
      gap_r[GAP_IW'(in_bank)] <= gap_nxt;
    end
  end

  // update stage registers
  logic              s1_valid_r;
  upd_ctl_t          s1_ctl_r;
  logic [SLOT_W-1:0] s1_slot_r;
  logic signed [15:0] s1_sample_r;
  logic signed [15:0] s1_zero_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_accept && s0_rmw;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_ctl_r.is_sample <= s0_sample;
      s1_ctl_r.bank      <= in_bank;
      s1_ctl_r.channel   <= in_channel;
      s1_slot_r          <= s0_slot;
      s1_sample_r        <= in_sample;
      s1_zero_r          <= in_new_zero;
    end
  end

  // state memory
  logic [WORD_BITS-1:0] mem_rd_data;
  logic [WORD_BITS-1:0] entry_cur, entry_new;
  res_t                 upd_res;

  zcpe_state_mem #(
    .DEPTH (SLOTS),
    .WIDTH (WORD_BITS),
    .AW    (SLOT_W)
  ) u_mem (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (in_accept && s0_rmw),
    .rd_addr  (s0_slot),
    .rd_data  (mem_rd_data),
    .wr_en    (s1_valid_r),
    .wr_addr  (s1_slot_r),
    .wr_data  (entry_new),
    .clr_busy (clr_busy)
  );

  // bypass of the entry written in the previous cycle: its read saw the old data
  logic                 byp_valid_r;
  logic [SLOT_W-1:0]    byp_slot_r;
  logic [WORD_BITS-1:0] byp_word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_valid_r <= 1'b0;
    end else begin
      byp_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      byp_slot_r <= s1_slot_r;
      byp_word_r <= entry_new;
    end
  end

  assign entry_cur = (byp_valid_r && (byp_slot_r == s1_slot_r)) ? byp_word_r : mem_rd_data;

  zcpe_update #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COUNT_BITS  (COUNT_BITS),
    .WORD_BITS   (WORD_BITS)
  ) u_update (
    .ctl       (s1_ctl_r),
    .sample    (s1_sample_r),
    .new_zero  (s1_zero_r),
    .gap       (gap_r[GAP_IW'(s1_ctl_r.bank)]),
    .entry_in  (entry_cur),
    .entry_out (entry_new),
    .result    (upd_res)
  );

  // result buffer
  logic       fifo_push, fifo_pop;
  logic [1:0] fifo_cnt;
  res_t       fifo_head;
  logic [2:0] held;

  assign fifo_push = s1_valid_r && s1_ctl_r.is_sample;
  assign fifo_pop  = out_valid && !out_stall;

  zcpe_res_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fifo_push),
    .push_data (upd_res),
    .pop       (fifo_pop),
    .not_empty (out_valid),
    .head      (fifo_head),
    .count     (fifo_cnt)
  );

  // results held in the buffer plus one in flight must fit two beats
  assign held     = 3'(fifo_cnt) + 3'(fifo_push) - 3'(fifo_pop);
  assign in_stall = clr_busy || (held > 3'd1);

  assign out_bank       = fifo_head.bank;
  assign out_channel    = fifo_head.channel;
  assign out_magnitude  = fifo_head.magnitude;
  assign out_period     = fifo_head.period;
  assign out_since_rise = fifo_head.since_rise;
  assign out_since_fall = fifo_head.since_fall;

`ifndef SYNTHESIS
  a_no_update_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy |-> !s1_valid_r)
    else $error("entry update while the memory is being cleared");

  a_buffer_fits: assert property (@(posedge clk) disable iff (!rst_n)
    (3'(fifo_cnt) + 3'(fifo_push)) <= 3'd2)
    else $error("result buffer overflow");

  a_sample_reaches_update: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && s0_sample) |=> (s1_valid_r && s1_ctl_r.is_sample))
    else $error("accepted sample lost before the update stage");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_push |=> out_valid)
    else $error("pushed result not offered");
`endif

endmodule
